// ----- rtl/jdcd_pkg.sv -----
// shared types, widths and calendar constants for the julian day to date converter
// used by jdcd_step_unit, jdcd_sequencer and julian_day_to_calendar_date
package jdcd_pkg;

    localparam int DAY_NUMBER_BITS = 31;

    // remainder register width: the largest shifted cycle length stays below 2**DAY_NUMBER_BITS
    localparam int ACC_BITS = DAY_NUMBER_BITS;
    // signed year accumulator, wide enough for the largest year and for the output saturation test
    localparam int YEAR_ACC_BITS = (DAY_NUMBER_BITS - 6 > 25) ? DAY_NUMBER_BITS - 6 : 25;
    localparam int STEP_BITS = $clog2(DAY_NUMBER_BITS);

    localparam int S_TDATA_BITS = ((DAY_NUMBER_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 40;

    localparam int DAY_BITS = 5;
    localparam int MONTH_BITS = 4;
    localparam int YEAR_BITS = 23;

    // first gregorian day and the shift to a 1 january 1201 origin
    localparam int GREG_START = 2299161;
    localparam int GREG_OFFSET = 2159717;
    localparam int GREG_BASE_YEAR = 1201;
    localparam int JUL_BASE_YEAR = -4712;

    localparam int DAYS_400 = 146097;
    localparam int DAYS_100 = 36524;
    localparam int DAYS_4 = 1461;
    localparam int DAYS_LEAP = 366;
    localparam int DAYS_YEAR = 365;
    localparam int YEAR_MAX = 8388607;

    // top bit position of the quotient of each long division
    localparam int G400_TOP = DAY_NUMBER_BITS - 18;
    localparam int G4_TOP = 4;
    localparam int JCYC_TOP = 10;
    localparam int CENTURY_STEPS = 3;
    localparam int YEAR_STEPS = 3;
    localparam int JUL_YEAR_STEPS = 2;
    localparam int LAST_MONTH_STEP = 10;

    typedef struct packed {
        logic                     load;
        logic                     step;
        logic [ACC_BITS-1:0]      operand;
        logic [YEAR_ACC_BITS-1:0] addend;
    } cmd_t;

    typedef struct packed {
        logic                  idle;
        logic                  fin;
        logic                  julian;
        logic [MONTH_BITS-1:0] month;
    } stat_t;

    function automatic logic [DAY_BITS-1:0] month_days(input logic [MONTH_BITS-1:0] m,
                                                       input logic leap);
        logic [DAY_BITS-1:0] len;
        case (m)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/jdcd_step_unit.sv -----
// shared compare and subtract unit with year accumulator
// depends on jdcd_pkg; driven by jdcd_sequencer
module jdcd_step_unit (
    input  logic                              aclk,
    input  jdcd_pkg::cmd_t                    cmd,
    output logic                              ge,
    output logic [jdcd_pkg::ACC_BITS-1:0]      acc,
    output logic [jdcd_pkg::YEAR_ACC_BITS-1:0] year
);

    logic [jdcd_pkg::ACC_BITS-1:0]      acc_reg;
    logic [jdcd_pkg::ACC_BITS-1:0]      acc_next;
    logic [jdcd_pkg::YEAR_ACC_BITS-1:0] year_reg;
    logic [jdcd_pkg::YEAR_ACC_BITS-1:0] year_next;

    assign ge = (acc_reg >= cmd.operand);

    always_comb begin
        acc_next = acc_reg;
        year_next = year_reg;
        if (cmd.load) begin
            acc_next = cmd.operand;
            year_next = cmd.addend;
        end else if (cmd.step && ge) begin
            acc_next = acc_reg - cmd.operand;
            year_next = year_reg + cmd.addend;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        year_reg <= year_next;
    end

    assign acc = acc_reg;
    assign year = year_reg;

endmodule

// ----- rtl/jdcd_sequencer.sv -----
// sequencer that walks the calendar cycles, years and months through the step unit
// depends on jdcd_pkg
module jdcd_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [jdcd_pkg::DAY_NUMBER_BITS-1:0] day_number,
    input  logic                                ge,
    input  logic                                out_free,
    output jdcd_pkg::cmd_t                      cmd,
    output jdcd_pkg::stat_t                     stat
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_G400  = 10'b0000000010,
        ST_G100  = 10'b0000000100,
        ST_G4    = 10'b0000001000,
        ST_GY    = 10'b0000010000,
        ST_JCYC  = 10'b0000100000,
        ST_J366  = 10'b0001000000,
        ST_JY    = 10'b0010000000,
        ST_MONTH = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    localparam int AB = jdcd_pkg::ACC_BITS;
    localparam int YB = jdcd_pkg::YEAR_ACC_BITS;
    localparam int SB = jdcd_pkg::STEP_BITS;

    state_t                            state_reg, state_next;
    logic [SB-1:0]                     k_reg, k_next;
    logic [1:0]                        c100_reg, c100_next;
    logic [4:0]                        c4_reg, c4_next;
    logic [1:0]                        y1_reg, y1_next;
    logic [jdcd_pkg::MONTH_BITS-1:0]   month_reg, month_next;
    logic                              leap_reg, leap_next;
    logic                              julian_reg, julian_next;
    logic                              is_julian;
    logic                              k_zero;

    assign is_julian = (day_number < jdcd_pkg::DAY_NUMBER_BITS'(jdcd_pkg::GREG_START));
    assign k_zero = (k_reg == '0);

    // operand and year weight for the current step
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = start;
                if (is_julian) begin
                    cmd.operand = AB'(day_number);
                    cmd.addend = YB'(jdcd_pkg::JUL_BASE_YEAR);
                end else begin
                    cmd.operand = AB'(day_number) - AB'(jdcd_pkg::GREG_OFFSET);
                    cmd.addend = YB'(jdcd_pkg::GREG_BASE_YEAR);
                end
            end
            ST_G400: begin
                cmd.step = 1'b1;
                cmd.operand = AB'(jdcd_pkg::DAYS_400) << k_reg;
                cmd.addend = YB'(400) << k_reg;
            end
            ST_G100: begin
                cmd.step = 1'b1;
                cmd.operand = AB'(jdcd_pkg::DAYS_100);
                cmd.addend = YB'(100);
            end
            ST_G4, ST_JCYC: begin
                cmd.step = 1'b1;
                cmd.operand = AB'(jdcd_pkg::DAYS_4) << k_reg;
                cmd.addend = YB'(4) << k_reg;
            end
            ST_GY, ST_JY: begin
                cmd.step = 1'b1;
                cmd.operand = AB'(jdcd_pkg::DAYS_YEAR);
                cmd.addend = YB'(1);
            end
            ST_J366: begin
                cmd.step = 1'b1;
                cmd.operand = AB'(jdcd_pkg::DAYS_LEAP);
                cmd.addend = YB'(1);
            end
            ST_MONTH: begin
                cmd.step = 1'b1;
                cmd.operand = AB'(jdcd_pkg::month_days(month_reg, leap_reg));
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        logic [1:0] y1_inc;
        y1_inc = y1_reg + 2'(ge);
        state_next = state_reg;
        k_next = k_reg;
        c100_next = c100_reg;
        c4_next = c4_reg;
        y1_next = y1_reg;
        month_next = month_reg;
        leap_next = leap_reg;
        julian_next = julian_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    c100_next = '0;
                    c4_next = '0;
                    y1_next = '0;
                    month_next = '0;
                    julian_next = is_julian;
                    if (is_julian) begin
                        state_next = ST_JCYC;
                        k_next = SB'(jdcd_pkg::JCYC_TOP);
                    end else begin
                        state_next = ST_G400;
                        k_next = SB'(jdcd_pkg::G400_TOP);
                    end
                end
            end
            ST_G400: begin
                k_next = k_reg - SB'(1);
                if (k_zero) begin
                    state_next = ST_G100;
                    k_next = SB'(jdcd_pkg::CENTURY_STEPS - 1);
                end
            end
            ST_G100: begin
                c100_next = c100_reg + 2'(ge);
                k_next = k_reg - SB'(1);
                if (k_zero) begin
                    state_next = ST_G4;
                    k_next = SB'(jdcd_pkg::G4_TOP);
                end
            end
            ST_G4: begin
                c4_next = {c4_reg[3:0], ge};
                k_next = k_reg - SB'(1);
                if (k_zero) begin
                    state_next = ST_GY;
                    k_next = SB'(jdcd_pkg::YEAR_STEPS - 1);
                end
            end
            ST_GY: begin
                y1_next = y1_inc;
                k_next = k_reg - SB'(1);
                if (k_zero) begin
                    state_next = ST_MONTH;
                    // last year of a 4-year group, unless a century year not divisible by 400
                    leap_next = (y1_inc == 2'd3) && !((c4_reg == 5'd24) && (c100_reg != 2'd3));
                end
            end
            ST_JCYC: begin
                k_next = k_reg - SB'(1);
                if (k_zero) begin
                    state_next = ST_J366;
                end
            end
            ST_J366: begin
                if (ge) begin
                    state_next = ST_JY;
                    k_next = SB'(jdcd_pkg::JUL_YEAR_STEPS - 1);
                    leap_next = 1'b0;
                end else begin
                    state_next = ST_MONTH;
                    leap_next = 1'b1;
                end
            end
            ST_JY: begin
                k_next = k_reg - SB'(1);
                if (k_zero) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (ge) begin
                    month_next = month_reg + 4'd1;
                    if (month_reg == jdcd_pkg::MONTH_BITS'(jdcd_pkg::LAST_MONTH_STEP)) begin
                        state_next = ST_FIN;
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        c100_reg <= c100_next;
        c4_reg <= c4_next;
        y1_reg <= y1_next;
        month_reg <= month_next;
        leap_reg <= leap_next;
        julian_reg <= julian_next;
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.fin = (state_reg == ST_FIN);
    assign stat.julian = julian_reg;
    assign stat.month = month_reg;

endmodule

// ----- rtl/julian_day_to_calendar_date.sv -----
// julian day number to julian or gregorian calendar date, top level
// depends on jdcd_pkg, jdcd_step_unit and jdcd_sequencer
//
// usage:
//   one request on the s_ side carries a day count from 1 january 4713 bc; one
//   result on the m_ side carries day, month, year and a bc flag for that day.
//   days before 15 october 1582 are julian dates, later ones gregorian.
// timing:
//   one compare and subtract unit does every step: the long division by the
//   cycle length, the century, year and month steps, one step per cycle.
//   a gregorian date also goes through the 400-year division and the century
//   steps, which a julian one skips. s_tready is high only while no request
//   is being worked on; the next request can be taken in the cycle after the
//   result enters the result register.
// reset and stalls:
//   aresetn (synchronous, active low) empties the result register and returns
//   the sequencer to idle. a stalled receiver holds the result; a finished
//   request then waits in the sequencer and no new request is taken.
module julian_day_to_calendar_date (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // day_number
    input  logic [jdcd_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // day_of_month, month_number, year_magnitude, before_christ
    output logic [jdcd_pkg::M_TDATA_BITS-1:0] m_tdata
);

    localparam int YB = jdcd_pkg::YEAR_ACC_BITS;

    jdcd_pkg::cmd_t                     cmd;
    jdcd_pkg::stat_t                    stat;
    logic                               ge;
    logic [jdcd_pkg::ACC_BITS-1:0]      acc;
    logic [YB-1:0]                      year;
    logic                               start;
    logic                               out_free;
    logic                               load_out;
    logic                               bc;
    logic [YB-1:0]                      mag;
    logic [jdcd_pkg::YEAR_BITS-1:0]     year_out;
    logic [jdcd_pkg::DAY_BITS-1:0]      day_out;
    logic [jdcd_pkg::MONTH_BITS-1:0]    month_out;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [jdcd_pkg::M_TDATA_BITS-1:0]  m_tdata_reg, m_tdata_next;

    assign start = s_tvalid && stat.idle;
    assign s_tready = stat.idle;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = stat.fin && out_free;

    jdcd_step_unit u_step (
        .aclk (aclk),
        .cmd  (cmd),
        .ge   (ge),
        .acc  (acc),
        .year (year)
    );

    jdcd_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .day_number (s_tdata[jdcd_pkg::DAY_NUMBER_BITS-1:0]),
        .ge         (ge),
        .out_free   (out_free),
        .cmd        (cmd),
        .stat       (stat)
    );

    // julian accumulator holds year - 4712 as signed: zero or below is a bc year
    always_comb begin
        bc = stat.julian && (year[YB-1] || (year == '0));
        mag = bc ? (YB'(1) - year) : year;
        if (mag > YB'(jdcd_pkg::YEAR_MAX)) begin
            year_out = jdcd_pkg::YEAR_BITS'(jdcd_pkg::YEAR_MAX);
        end else begin
            year_out = mag[jdcd_pkg::YEAR_BITS-1:0];
        end
        day_out = acc[jdcd_pkg::DAY_BITS-1:0] + 5'd1;
        month_out = stat.month + 4'd1;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next = {7'd0, bc, year_out, month_out, day_out};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a conversion was under way");

    a_result_registered: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.fin && out_free |=> m_tvalid && stat.idle)
        else $error("finished conversion did not reach the result register");

    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:0] != 5'd0) && (m_tdata[8:5] != 4'd0)
                     && (m_tdata[8:5] <= 4'd12) && (m_tdata[31:9] != 23'd0))
        else $error("day, month or year out of range");

    a_bc_year_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> (m_tdata[31:9] <= 23'd4713))
        else $error("bc year beyond the start of the day count");

endmodule

// ----- test/tb_julian_day_to_calendar_date.sv -----
// self-checking testbench for julian_day_to_calendar_date: random and edge-case day numbers
// against a behavioural calendar predictor, with bursty requests and a stalling receiver
// depends on jdcd_pkg and the julian_day_to_calendar_date rtl
`timescale 1ns / 1ps

module tb_julian_day_to_calendar_date;

    localparam int S_W = jdcd_pkg::S_TDATA_BITS;
    localparam int M_W = jdcd_pkg::M_TDATA_BITS;
    localparam int DN_BITS = jdcd_pkg::DAY_NUMBER_BITS;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 80;
    localparam int LIMIT_CYCLES = 500000;
    localparam int LONG_HOLD_CYCLES = 600;

    localparam longint unsigned FIRST_GREGORIAN = 2299161;
    localparam longint unsigned FIRST_AD_DAY = 1721424;
    // day number a proleptic gregorian 1 january 1201 would have
    localparam longint unsigned GREG_ORIGIN = 2159717;
    localparam longint unsigned CYCLE_400Y = 146097;
    localparam longint unsigned CYCLE_100Y = 36524;
    localparam longint unsigned CYCLE_4Y = 1461;
    localparam longint unsigned LEAP_YEAR_DAYS = 366;
    localparam longint unsigned PLAIN_YEAR_DAYS = 365;
    localparam longint unsigned YEAR_CEILING = 8388607;
    localparam longint unsigned DAY_MASK = (64'd1 << DN_BITS) - 1;

    typedef struct packed {
        logic [jdcd_pkg::DAY_BITS-1:0]   day;
        logic [jdcd_pkg::MONTH_BITS-1:0] month;
        logic [jdcd_pkg::YEAR_BITS-1:0]  year;
        logic                            bc;
    } calendar_date_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    int sent = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    julian_day_to_calendar_date u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic calendar_date_t calendar_of(input logic [S_W-1:0] word);
        longint unsigned days, cyc, rem, yo, q, t, c400, c100, c4, y1, year, doy, len;
        logic leap, bc;
        int m;
        calendar_date_t d;
        days = 64'(word);
        days = days & DAY_MASK;
        bc = 1'b0;
        if (days < FIRST_GREGORIAN) begin
            // julian cycles open with the leap year
            cyc = days / CYCLE_4Y;
            rem = days % CYCLE_4Y;
            if (rem < LEAP_YEAR_DAYS) begin
                yo = 0;
                doy = rem;
            end else begin
                yo = 1 + (rem - LEAP_YEAR_DAYS) / PLAIN_YEAR_DAYS;
                doy = (rem - LEAP_YEAR_DAYS) % PLAIN_YEAR_DAYS;
            end
            leap = (yo == 0);
            q = cyc * 4 + yo;
            if (q < 4713) begin
                bc = 1'b1;
                year = 4713 - q;
            end else begin
                year = q - 4712;
            end
        end else begin
            t = days - GREG_ORIGIN;
            c400 = t / CYCLE_400Y;
            t = t % CYCLE_400Y;
            c100 = t / CYCLE_100Y;
            if (c100 > 3) c100 = 3;
            t = t - c100 * CYCLE_100Y;
            c4 = t / CYCLE_4Y;
            t = t - c4 * CYCLE_4Y;
            y1 = t / PLAIN_YEAR_DAYS;
            if (y1 > 3) y1 = 3;
            doy = t - y1 * PLAIN_YEAR_DAYS;
            year = 1201 + c400 * 400 + c100 * 100 + c4 * 4 + y1;
            leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
        end
        m = 0;
        while (m < 11) begin
            if (m == 1) len = leap ? 29 : 28;
            else if (m == 3 || m == 5 || m == 8 || m == 10) len = 30;
            else len = 31;
            if (doy < len) break;
            doy = doy - len;
            m++;
        end
        if (year > YEAR_CEILING) year = YEAR_CEILING;
        d.day = jdcd_pkg::DAY_BITS'(doy + 1);
        d.month = jdcd_pkg::MONTH_BITS'(m + 1);
        d.year = jdcd_pkg::YEAR_BITS'(year);
        d.bc = bc;
        return d;
    endfunction

    class date_scoreboard;
        calendar_date_t expected_dates[$];
        int errors = 0;

        function void note_request(input logic [S_W-1:0] word);
            expected_dates.push_back(calendar_of(word));
        endfunction

        function void check_result(input logic [M_W-1:0] word);
            calendar_date_t want, got;
            if (expected_dates.size() == 0) begin
                $error("result 0x%0h arrived with no request outstanding", word);
                errors++;
                return;
            end
            want = expected_dates.pop_front();
            got.day = word[4:0];
            got.month = word[8:5];
            got.year = word[31:9];
            got.bc = word[32];
            if (got.day !== want.day) begin
                $error("day_of_month: expected %0d, got %0d", want.day, got.day);
                errors++;
            end
            if (got.month !== want.month) begin
                $error("month_number: expected %0d, got %0d", want.month, got.month);
                errors++;
            end
            if (got.year !== want.year) begin
                $error("year_magnitude: expected %0d, got %0d", want.year, got.year);
                errors++;
            end
            if (got.bc !== want.bc) begin
                $error("before_christ: expected %0d, got %0d", want.bc, got.bc);
                errors++;
            end
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    date_scoreboard dates = new();

    function automatic logic [S_W-1:0] random_day();
        longint unsigned near, k, yo, v;
        near = 0;
        case ($urandom_range(0, 7))
            0: near = 0;
            1: near = 58;
            2: near = 59;
            3: near = 60;
            4: near = 364;
            5: near = 365;
            6: near = 366;
            default: near = $urandom_range(0, 1460);
        endcase
        case ($urandom_range(0, 7))
            0: v = $urandom;
            1: v = $urandom_range(0, FIRST_AD_DAY - 1);
            2: v = $urandom_range(FIRST_AD_DAY, FIRST_GREGORIAN - 1);
            3: v = FIRST_GREGORIAN - 1500 + $urandom_range(0, 3000);
            4: begin
                // julian year starts inside a four-year cycle
                k = $urandom_range(0, 1573);
                yo = $urandom_range(0, 3);
                v = k * CYCLE_4Y + near + ((yo == 0) ? 0 : 1 + yo * PLAIN_YEAR_DAYS);
            end
            5: begin
                k = $urandom_range(0, 14000);
                v = GREG_ORIGIN + k * CYCLE_400Y + $urandom_range(0, 3) * CYCLE_100Y
                    + $urandom_range(0, 1) * 24 * CYCLE_4Y
                    + $urandom_range(0, 3) * PLAIN_YEAR_DAYS + near;
            end
            6: begin
                if ($urandom_range(0, 1) == 0) begin
                    // last days of a 400-year cycle
                    k = $urandom_range(0, 14000);
                    v = GREG_ORIGIN + (k + 1) * CYCLE_400Y - 1 - $urandom_range(0, 3);
                end else begin
                    v = $urandom_range(FIRST_GREGORIAN, 2816787);
                end
            end
            default: v = DAY_MASK - $urandom_range(0, 100000);
        endcase
        return S_W'(v & DAY_MASK);
    endfunction

    task automatic send_day(input logic [S_W-1:0] word);
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        dates.note_request(word);
        sent++;
    endtask

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // edge cases: calendar extremes, the 1582 switch, leap and century rules, unused top bit
    logic [S_W-1:0] edge_days [21] = '{
        32'd0, 32'd1, 32'd59, 32'd365, 32'd366, 32'd1460, 32'd1461,
        32'(FIRST_AD_DAY - 1), 32'(FIRST_AD_DAY),
        32'(FIRST_GREGORIAN - 1), 32'(FIRST_GREGORIAN),
        32'(GREG_ORIGIN + CYCLE_4Y - 1),
        32'(GREG_ORIGIN + CYCLE_400Y - 1),
        32'(GREG_ORIGIN + CYCLE_400Y + 2 * CYCLE_100Y + 24 * CYCLE_4Y + 3 * 365 + 59),
        32'(GREG_ORIGIN + CYCLE_400Y + 3 * CYCLE_100Y + 24 * CYCLE_4Y + 3 * 365 + 59),
        32'(GREG_ORIGIN + 2 * CYCLE_400Y - 1),
        32'h5555_5555, 32'h2AAA_AAAA, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF
    };

    initial begin : sender
        int idx, burst;
        logic paused;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (edge_days[i]) begin
            send_day(edge_days[i]);
            if (i % 5 == 4) idle_sender($urandom_range(1, 30));
        end
        idx = 0;
        while (idx < RANDOM_ITEMS) begin
            if (!paused && idx >= RANDOM_ITEMS / 2) begin
                // hold until the block has drained every outstanding request
                paused = 1'b1;
                s_tvalid <= 1'b0;
                while (dates.pending() != 0) @(posedge aclk);
            end
            burst = $urandom_range(1, 16);
            while (burst > 0 && idx < RANDOM_ITEMS) begin
                send_day(random_day());
                idx++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 50));
        end
        s_tvalid <= 1'b0;
        while (dates.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (dates.errors == 0 && dates.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : receiver
        int mode, mode_left, phase, hold_left;
        logic held_once;
        mode = 0;
        mode_left = 0;
        phase = 0;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_once && sent >= 300) begin
                // long back-pressure so the block fills and stalls its input
                held_once = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 250);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= ((phase % 7) < 4);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) dates.check_result(m_tdata);
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/jdcd_pkg.sv
rtl/jdcd_step_unit.sv
rtl/jdcd_sequencer.sv
rtl/julian_day_to_calendar_date.sv
test/tb_julian_day_to_calendar_date.sv
